// ----- rtl/periodic_task_dispatcher_defines.svh -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher assertion macros
// Shared assertion forms for the checker of the dispatcher ports.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptd_pkg.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher package
// Widths, reset intervals, command codes and controller types.
// ---------------------------------------------------------------------------
package ptd_pkg;

  localparam int NUM_SLOTS_DEF = 5;
  localparam int NUM_REGS      = 5;
  localparam int IVL_W         = 24;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 3;
  localparam int CNT_W         = 8;
  localparam int CFG_IDX_W     = 3;

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Reset interval of a slot; slots without a register reset to zero.
  function automatic logic [IVL_W-1:0] ivl_reset_val(input int slot);
    logic [IVL_W-1:0] val;
    case (slot)
      0:       val = IVL_W'(2000);
      1:       val = IVL_W'(6000);
      2:       val = IVL_W'(11000);
      3:       val = IVL_W'(20000);
      4:       val = IVL_W'(50000);
      default: val = '0;
    endcase
    return val;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ptd_state_t;

  typedef struct packed {
    logic count_tick;
    logic load_poll;
    logic scan_en;
    logic emit_en;
  } ptd_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic mask_empty;
  } ptd_status_t;

endpackage

// ----- rtl/ptd_if.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher channels
// Valid/ready channels for input items and dispatch results.
// ---------------------------------------------------------------------------
interface ptd_in_if
  import ptd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] time_now_us;

  modport source (output valid, output command, output time_now_us, input ready);
  modport sink   (input valid, input command, input time_now_us, output ready);
endinterface

interface ptd_out_if
  import ptd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   task_id;
  logic [TIME_W-1:0] elapsed_us;
  logic              last_result;

  modport source (output valid, output task_id, output elapsed_us, output last_result,
                  input ready);
  modport sink   (input valid, input task_id, input elapsed_us, input last_result,
                  output ready);
endinterface

// ----- rtl/ptd_ctrl.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher controller
// Sequences accept, slot scan and result emission phases.
// ---------------------------------------------------------------------------
module ptd_ctrl
  import ptd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_command,
  output logic        in_ready,
  input  ptd_status_t sts,
  output ptd_cmd_t    cmd
);

  ptd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_POLL) begin
            cmd.load_poll = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.count_tick = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_en = 1'b1;
        if (sts.mask_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ptd_dp.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher datapath
// Interval registers, last-run times, due mask and result register.
// ---------------------------------------------------------------------------
module ptd_dp
  import ptd_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptd_cmd_t             cmd,
  output ptd_status_t          sts,
  input  logic [TIME_W-1:0]    in_time_now_us,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IVL_W-1:0]     cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ID_W-1:0]      out_task_id,
  output logic [TIME_W-1:0]    out_elapsed_us,
  output logic                 out_last_result
);

  localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [CNT_W-1:0]  pending_r;
  logic [TIME_W-1:0] now_r;
  logic [NUM_SLOTS:0] mask_r;
  logic [SLOT_W-1:0] scan_idx_r;
  logic [IDX_W-1:0]  emit_idx_r;
  logic [TIME_W-1:0] last_run_r [NUM_SLOTS];
  logic [IVL_W-1:0]  ivl_r [NUM_SLOTS];

  logic              out_valid_r;
  logic [ID_W-1:0]   task_id_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              last_r;

  logic [SLOT_W-1:0]  emit_slot;
  logic [SLOT_W-1:0]  rd_slot;
  logic [TIME_W-1:0]  diff;
  logic               due;
  logic               cur_bit;
  logic [NUM_SLOTS:0] mask_rest;
  logic               out_free;
  logic               emit_fire;
  logic               emit_skip;

  always_comb begin
    emit_slot = SLOT_W'(emit_idx_r - IDX_W'(1));
    rd_slot   = cmd.emit_en ? emit_slot : scan_idx_r;
    diff      = now_r - last_run_r[rd_slot];
    due       = (diff >= TIME_W'(ivl_r[rd_slot]));
    cur_bit   = mask_r[emit_idx_r];
    mask_rest = mask_r;
    mask_rest[emit_idx_r] = 1'b0;
    out_free  = !out_valid_r || out_ready;
    emit_fire = cmd.emit_en && cur_bit && out_free;
    emit_skip = cmd.emit_en && !cur_bit && (mask_r != '0);
    sts.scan_last  = (scan_idx_r == SLOT_W'(NUM_SLOTS - 1));
    sts.mask_empty = (mask_r == '0);
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      mask_r      <= '0;
      scan_idx_r  <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        last_run_r[i] <= '0;
        ivl_r[i]      <= ivl_reset_val(i);
      end
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i < NUM_REGS && cfg_index == CFG_IDX_W'(i)) begin
            ivl_r[i] <= cfg_wdata;
          end
        end
      end
      if (cmd.count_tick) begin
        pending_r <= pending_r + CNT_W'(1);
      end
      if (cmd.load_poll) begin
        mask_r     <= {{NUM_SLOTS{1'b0}}, (pending_r != '0)};
        scan_idx_r <= '0;
        emit_idx_r <= '0;
        if (pending_r != '0) begin
          pending_r <= pending_r - CNT_W'(1);
        end
      end
      if (cmd.scan_en) begin
        mask_r[IDX_W'(scan_idx_r) + IDX_W'(1)] <= due;
        scan_idx_r <= scan_idx_r + SLOT_W'(1);
      end
      if (emit_fire) begin
        mask_r[emit_idx_r] <= 1'b0;
        emit_idx_r         <= emit_idx_r + IDX_W'(1);
        if (emit_idx_r != '0) begin
          last_run_r[emit_slot] <= now_r;
        end
      end else if (emit_skip) begin
        emit_idx_r <= emit_idx_r + IDX_W'(1);
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_poll) begin
      now_r <= in_time_now_us;
    end
    if (emit_fire) begin
      task_id_r <= ID_W'(emit_idx_r);
      elapsed_r <= (emit_idx_r == '0) ? '0 : diff;
      last_r    <= (mask_rest == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_task_id     = task_id_r;
  assign out_elapsed_us  = elapsed_r;
  assign out_last_result = last_r;

endmodule

// ----- rtl/periodic_task_dispatcher.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher
// Time-triggered scheduler for one fast task and a set of periodic slots.
// The input channel carries ticks (command 0) and polls (command 1, with the
// current microsecond time). A tick bumps the 8-bit pending fast-task count.
// A poll dispatches the fast task once if runs are pending, then every slot
// whose wrapping elapsed time has reached its interval, in slot order; each
// dispatch is one transaction on the result channel, and the last one of a
// poll carries last_result. After a poll is taken, the slots are checked one
// per cycle on one shared subtract and compare, then the result walk steps
// from the fast-task bit to the last due slot, one bit per cycle while the
// result stage is free, and returns to idle once the due mask is empty.
// A stalled receiver holds the registered result and the walk waits on it;
// the next input may be taken while the last result of a poll still waits.
// Reset (rst_n low, synchronous) clears the pending count and last-run times
// and restores the default intervals; write intervals only while idle.
// ---------------------------------------------------------------------------
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ptd_in_if.sink               in_ch,
  ptd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IVL_W-1:0]     cfg_wdata
);

  // Command and status bundles between the controller and the datapath.
  ptd_cmd_t    cmd;
  ptd_status_t sts;

  // The controller owns the input handshake and the phase sequencing.
  ptd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the architectural state and the registered result stage, so the
  // result handshake is resolved there without controller involvement.
  ptd_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_time_now_us  (in_ch.time_now_us),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_task_id     (out_ch.task_id),
    .out_elapsed_us  (out_ch.elapsed_us),
    .out_last_result (out_ch.last_result)
  );

endmodule

// ----- rtl/ptd_checker.sv -----
// ---------------------------------------------------------------------------
// Periodic task dispatcher checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "periodic_task_dispatcher_defines.svh"

module ptd_checker
  import ptd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   out_task_id,
  input logic [TIME_W-1:0] out_elapsed_us,
  input logic              out_last_result
);

  logic tick_acc;
  logic poll_acc;

  assign tick_acc = in_valid && in_ready && (in_command == CMD_TICK);
  assign poll_acc = in_valid && in_ready && (in_command == CMD_POLL);

  `PTD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_task_id) && $stable(out_elapsed_us) && $stable(out_last_result),
    "result changed while stalled")
  `PTD_ASSERT_NEXT(a_tick_no_result, clk, rst_n, tick_acc, !$rose(out_valid),
    "tick produced a result")
  `PTD_ASSERT_NEXT(a_poll_busy, clk, rst_n, poll_acc, !in_ready,
    "input reopened right after a poll")
  `PTD_ASSERT_SAME(a_fast_zero, clk, rst_n, out_valid && (out_task_id == '0),
    out_elapsed_us == '0, "fast task result with nonzero elapsed time")

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_task_id     (out_ch.task_id),
  .out_elapsed_us  (out_ch.elapsed_us),
  .out_last_result (out_ch.last_result)
);
